FILE: rtl/core/mandelbrot_escape_time_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/met_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types and constants for the escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none
package met_pkg;

  localparam int unsigned COORD_W      = 32;
  localparam int unsigned ITER_W       = 16;
  localparam int unsigned PIX_W        = 12;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned FRAC_BITS_DEF = 28;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

  localparam logic signed [COORD_W-1:0] ORIGIN_REAL_RST = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] ORIGIN_IMAG_RST = -32'sd402653184;
  localparam logic signed [COORD_W-1:0] STEP_REAL_RST   = 32'sd262144;
  localparam logic signed [COORD_W-1:0] STEP_IMAG_RST   = 32'sd262144;
  localparam logic [ITER_W-1:0]         ITER_LIMIT_RST  = 16'd256;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_real;
    logic signed [COORD_W-1:0] origin_imag;
    logic signed [COORD_W-1:0] step_real;
    logic signed [COORD_W-1:0] step_imag;
    logic [ITER_W-1:0]         iteration_limit;
  } met_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/met_cfg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time configuration registers
// Holds the view window and the iteration limit, written by index.
// ----------------------------------------------------------------------------
`default_nettype none
module met_cfg (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [met_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [met_pkg::COORD_W-1:0]           cfg_data,
  output met_pkg::met_cfg_t                    cfg
);
  import met_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_real     <= ORIGIN_REAL_RST;
      cfg.origin_imag     <= ORIGIN_IMAG_RST;
      cfg.step_real       <= STEP_REAL_RST;
      cfg.step_imag       <= STEP_IMAG_RST;
      cfg.iteration_limit <= ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to unknown indexes
      unique case (cfg_index)
        REG_ORIGIN_REAL: cfg.origin_real     <= cfg_data;
        REG_ORIGIN_IMAG: cfg.origin_imag     <= cfg_data;
        REG_STEP_REAL:   cfg.step_real       <= cfg_data;
        REG_STEP_IMAG:   cfg.step_imag       <= cfg_data;
        REG_ITER_LIMIT:  cfg.iteration_limit <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/met_mul.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shared multiplier
// Signed 33x33 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none
module met_mul (
  input  wire                           clk,
  input  wire signed [met_pkg::COORD_W:0] a,
  input  wire signed [met_pkg::COORD_W:0] b,
  output logic signed [2*met_pkg::COORD_W-1:0] p
);
  import met_pkg::*;

  logic signed [2*COORD_W+1:0] full;

  assign full = a * b;

  // every product used here fits in 64 bits
  always_ff @(posedge clk) begin
    p <= full[2*COORD_W-1:0];
  end

endmodule
`default_nettype wire

FILE: rtl/core/met_core.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time sequencer and datapath
// Steps one pixel's orbit through the shared multiplier, three products
// per iteration, and reports the escape step.
// ----------------------------------------------------------------------------
`default_nettype none
module met_core #(
  parameter int unsigned FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  met_pkg::met_cfg_t                cfg,
  input  wire                              start,
  input  wire [met_pkg::PIX_W-1:0]         column,
  input  wire [met_pkg::PIX_W-1:0]         row,
  output logic                             busy,
  output logic                             done,
  output logic [met_pkg::ITER_W-1:0]       iterations
);
  import met_pkg::*;

  localparam int unsigned PROD_W = 2 * COORD_W;
  localparam logic signed [PROD_W-1:0] ESC_BOUND = 64'sd4 <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] SAT_MAX   = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN   = -64'sd2147483648;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CRE    = 8'b0000_0010,
    ST_CIM    = 8'b0000_0100,
    ST_LOAD   = 8'b0000_1000,
    ST_SQRE   = 8'b0001_0000,
    ST_SQIM   = 8'b0010_0000,
    ST_CROSS  = 8'b0100_0000,
    ST_UPDATE = 8'b1000_0000
  } state_t;

  state_t state;

  logic [PIX_W-1:0]          col_q;
  logic [PIX_W-1:0]          row_q;
  logic signed [COORD_W-1:0] cre;
  logic signed [COORD_W-1:0] cim;
  logic signed [COORD_W-1:0] zre;
  logic signed [COORD_W-1:0] zim;
  logic signed [PROD_W-1:0]  r2;
  logic signed [PROD_W-1:0]  i2;
  logic [ITER_W-1:0]         k;

  logic signed [COORD_W:0]   mul_a;
  logic signed [COORD_W:0]   mul_b;
  logic signed [PROD_W-1:0]  p;
  logic signed [PROD_W-1:0]  sq_now;
  logic signed [PROD_W-1:0]  cross_now;
  logic signed [PROD_W-1:0]  mag2;
  logic signed [PROD_W-1:0]  origin_sum;
  logic signed [PROD_W-1:0]  zim_sum;
  logic signed [PROD_W-1:0]  zre_sum;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      ST_CRE: begin
        mul_a = $signed({{(COORD_W+1-PIX_W){1'b0}}, col_q});
        mul_b = {cfg.step_real[COORD_W-1], cfg.step_real};
      end
      ST_CIM: begin
        mul_a = $signed({{(COORD_W+1-PIX_W){1'b0}}, row_q});
        mul_b = {cfg.step_imag[COORD_W-1], cfg.step_imag};
      end
      ST_SQRE: begin
        mul_a = {zre[COORD_W-1], zre};
        mul_b = {zre[COORD_W-1], zre};
      end
      ST_SQIM: begin
        mul_a = {zim[COORD_W-1], zim};
        mul_b = {zim[COORD_W-1], zim};
      end
      default: begin
        mul_a = {zre[COORD_W-1], zre};
        mul_b = {zim[COORD_W-1], zim};
      end
    endcase
  end

  met_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  // arithmetic shift rounds toward minus infinity
  assign sq_now     = p >>> FRAC_BITS;
  assign cross_now  = p >>> (FRAC_BITS - 1);
  assign mag2       = r2 + sq_now;
  assign origin_sum = (state == ST_CIM)
                      ? PROD_W'(cfg.origin_real) + p
                      : PROD_W'(cfg.origin_imag) + p;
  assign zim_sum    = cross_now + PROD_W'(cim);
  assign zre_sum    = r2 - i2 + PROD_W'(cre);

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CRE;
          end
        end
        ST_CRE:  state <= ST_CIM;
        ST_CIM:  state <= ST_LOAD;
        ST_LOAD: state <= ST_SQRE;
        ST_SQRE: begin
          if (k == cfg.iteration_limit) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_SQIM;
          end
        end
        ST_SQIM: state <= ST_CROSS;
        ST_CROSS: begin
          if (mag2 > ESC_BOUND) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: state <= ST_SQRE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        col_q <= column;
        row_q <= row;
        k     <= '0;
      end
      ST_CIM: begin
        cre <= sat32(origin_sum);
        zre <= sat32(origin_sum);
      end
      ST_LOAD: begin
        cim <= sat32(origin_sum);
        zim <= sat32(origin_sum);
      end
      ST_SQRE: begin
        iterations <= k;
      end
      ST_SQIM: begin
        r2 <= sq_now;
      end
      ST_CROSS: begin
        i2 <= sq_now;
      end
      ST_UPDATE: begin
        zim <= sat32(zim_sum);
        zre <= sat32(zre_sum);
        k   <= k + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Maps a pixel to a point c and counts orbit steps until |z|^2 exceeds four.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low. The block stays busy
// until its result is out: iterations appears with done for one cycle, and
// the receiver must take it then, as nothing holds it. A single 33x33
// multiplier does all the work: the CRE, CIM and LOAD states map column and
// row to c and load the orbit, and each orbit step runs through SQRE, SQIM,
// CROSS and UPDATE (three products and an update). A pixel that escapes at
// step k reports k; one that reaches the limit L reports L, 256 by default.
// Registers are written over the cfg channel, always ready; the user must
// write them only while idle, as the block itself does not enforce this.
`default_nettype none
`include "mandelbrot_escape_time_defines.svh"
module mandelbrot_escape_time #(
  parameter int unsigned FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire [met_pkg::PIX_W-1:0]        column,
  input  wire [met_pkg::PIX_W-1:0]        row,
  output logic                            done,
  output logic [met_pkg::ITER_W-1:0]      iterations,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [met_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [met_pkg::COORD_W-1:0]      cfg_data
);
  import met_pkg::*;

  met_cfg_t cfg;

  met_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  met_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start && !busy),
    .column     (column),
    .row        (row),
    .busy       (busy),
    .done       (done),
    .iterations (iterations)
  );

  `MET_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `MET_ASSERT_SAME(a_done_when_idle, done, !busy)
  `MET_ASSERT_SAME(a_result_within_limit, done, iterations <= cfg.iteration_limit)
  `MET_ASSERT_NEXT(a_done_single_pulse, done, !done)

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time testbench
// Drives pixels through the start/busy port and rewrites the mapping
// registers between batches. Every iterations strobe is checked against a
// typed-in count or a Q4.28 model of the escape loop that runs in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import met_pkg::*;

  localparam int     FRAC             = FRAC_BITS_DEF;
  localparam longint ESCAPE_BOUND     = longint'(4) <<< FRAC;
  localparam longint WORD_MAX         = 64'sd2147483647;
  localparam longint WORD_MIN         = -64'sd2147483648;
  localparam int     RANDOM_PHASES    = 12;
  localparam int     PIXELS_PER_PHASE = 110;
  localparam int     TAIL_CYCLES      = 200;

  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} plan_kind_t;

  typedef struct packed {
    plan_kind_t           kind;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;
    logic [PIX_W-1:0]     col;
    logic [PIX_W-1:0]     rw;
    logic                 typed_in;
    logic [ITER_W-1:0]    want;
  } plan_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     column    = '0;
  logic [PIX_W-1:0]     row       = '0;
  logic                 done;
  logic [ITER_W-1:0]    iterations;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data  = '0;

  // bench copy of the mapping registers
  logic signed [COORD_W-1:0] map_origin_re = ORIGIN_REAL_RST;
  logic signed [COORD_W-1:0] map_origin_im = ORIGIN_IMAG_RST;
  logic signed [COORD_W-1:0] map_step_re   = STEP_REAL_RST;
  logic signed [COORD_W-1:0] map_step_im   = STEP_IMAG_RST;
  logic [ITER_W-1:0]         map_limit     = ITER_LIMIT_RST;

  logic [ITER_W-1:0] pending_counts[$];
  logic [ITER_W-1:0] want_count;
  int idle_pct    = 0;
  int mismatches  = 0;
  int checked     = 0;
  int pixels_sent = 0;
  int reg_writes  = 0;
  int deepest     = int'(ITER_LIMIT_RST);

  mandelbrot_escape_time dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .column     (column),
    .row        (row),
    .done       (done),
    .iterations (iterations),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #12_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // Escape step of one pixel under the current register copy.
  function automatic logic [ITER_W-1:0] escape_step(input logic [PIX_W-1:0] c,
                                                    input logic [PIX_W-1:0] r);
    longint c_re, c_im, z_re, z_im, re_sq, im_sq, cross_t;
    logic [ITER_W-1:0] steps;
    logic escaped;
    int k;
    c_re = clamp_word(longint'(map_origin_re) + longint'(c) * longint'(map_step_re));
    c_im = clamp_word(longint'(map_origin_im) + longint'(r) * longint'(map_step_im));
    z_re = c_re;
    z_im = c_im;
    steps = map_limit;
    escaped = 1'b0;
    k = 0;
    while (!escaped && k < int'(map_limit)) begin
      // products floor back to FRAC fraction bits
      re_sq = (z_re * z_re) >>> FRAC;
      im_sq = (z_im * z_im) >>> FRAC;
      if (re_sq + im_sq > ESCAPE_BOUND) begin
        steps = k[ITER_W-1:0];
        escaped = 1'b1;
      end else begin
        cross_t = (z_re * z_im) >>> (FRAC - 1);
        z_im = clamp_word(cross_t + c_im);
        z_re = clamp_word(re_sq - im_sq + c_re);
        k++;
      end
    end
    return steps;
  endfunction

  function automatic plan_row_t pixel_row(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] r,
                                          input logic typed_in, input logic [ITER_W-1:0] want);
    plan_row_t p;
    p = '0;
    p.kind = ROW_PIXEL;
    p.col = c;
    p.rw = r;
    p.typed_in = typed_in;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [COORD_W-1:0] data);
    plan_row_t p;
    p = '0;
    p.kind = ROW_WRITE;
    p.index = idx;
    p.data = data;
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_REAL: map_origin_re = data;
      REG_ORIGIN_IMAG: map_origin_im = data;
      REG_STEP_REAL:   map_step_re = data;
      REG_STEP_IMAG:   map_step_im = data;
      REG_ITER_LIMIT: begin
        map_limit = data[ITER_W-1:0];
        if (int'(map_limit) > deepest) deepest = int'(map_limit);
      end
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] r,
                            input logic typed_in, input logic [ITER_W-1:0] want);
    int gap;
    cfg_valid <= 1'b0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 40);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    column <= c;
    row    <= r;
    do @(posedge clk); while (busy);
    pending_counts.push_back(typed_in ? want : escape_step(c, r));
    pixels_sent++;
  endtask

  // Drop start and wait until every pixel in flight has reported.
  task automatic settle();
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: iterations strobe with nothing pending, expected none, actual %0d",
                 $time, iterations);
        mismatches++;
      end else begin
        want_count = pending_counts.pop_front();
        checked++;
        if (iterations !== want_count) begin
          $display("%0t: iterations mismatch, expected %0d, actual %0d",
                   $time, want_count, iterations);
          mismatches++;
        end
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    plan_row_t pr;
    logic signed [COORD_W-1:0] o_re, o_im, s_re, s_im;
    logic [ITER_W-1:0] lim, junk;
    logic [CFG_IDX_W-1:0] stray_idx;
    int phase, n, region, directed_pixels;

    // reset mapping: column 0 at -2.0, row 0 at -1.5, step 2^-10, limit 256
    plan.push_back(pixel_row(12'd0,    12'd0,    1'b1, 16'd0));
    plan.push_back(pixel_row(12'd2048, 12'd1536, 1'b1, 16'd256));   // c = 0
    plan.push_back(pixel_row(12'd4095, 12'd4095, 1'b1, 16'd0));
    plan.push_back(pixel_row(12'd1024, 12'd1536, 1'b1, 16'd256));   // c = -1, period two
    plan.push_back(pixel_row(12'd0,    12'd1536, 1'b1, 16'd256));   // |z|^2 sits at exactly 4
    plan.push_back(pixel_row(12'd2560, 12'd1536, 1'b0, 16'd0));
    plan.push_back(pixel_row(12'd2048, 12'd2560, 1'b0, 16'd0));
    // zero limit
    plan.push_back(write_row(REG_ITER_LIMIT, 32'd0));
    plan.push_back(pixel_row(12'd4095, 12'd4095, 1'b1, 16'd0));
    plan.push_back(pixel_row(12'd2048, 12'd1536, 1'b1, 16'd0));
    // upper data bits must not reach the limit
    plan.push_back(write_row(REG_ITER_LIMIT, 32'hABCD_0010));
    plan.push_back(pixel_row(12'd2048, 12'd1536, 1'b1, 16'd16));
    plan.push_back(write_row(REG_UNUSED_LO, 32'hFFFF_FFFF));
    plan.push_back(write_row(REG_UNUSED_LO + 3'd1, 32'h0000_0000));
    plan.push_back(write_row(REG_UNUSED_HI, 32'h1234_5678));
    plan.push_back(pixel_row(12'd1024, 12'd1536, 1'b1, 16'd16));
    plan.push_back(write_row(REG_ITER_LIMIT, 32'd1));
    plan.push_back(pixel_row(12'd2048, 12'd1536, 1'b1, 16'd1));
    plan.push_back(pixel_row(12'd0,    12'd0,    1'b1, 16'd0));
    // mapping at the word extremes, c saturates
    plan.push_back(write_row(REG_ORIGIN_REAL, 32'h7FFF_FFFF));
    plan.push_back(write_row(REG_ORIGIN_IMAG, 32'h8000_0000));
    plan.push_back(write_row(REG_STEP_REAL,   32'h7FFF_FFFF));
    plan.push_back(write_row(REG_STEP_IMAG,   32'h8000_0000));
    plan.push_back(write_row(REG_ITER_LIMIT,  32'd8));
    plan.push_back(pixel_row(12'd0,    12'd0,    1'b1, 16'd0));
    plan.push_back(pixel_row(12'd4095, 12'd4095, 1'b1, 16'd0));
    plan.push_back(write_row(REG_ORIGIN_REAL, 32'h8000_0000));
    plan.push_back(write_row(REG_ORIGIN_IMAG, 32'h7FFF_FFFF));
    plan.push_back(write_row(REG_STEP_REAL,   32'h8000_0000));
    plan.push_back(write_row(REG_STEP_IMAG,   32'h7FFF_FFFF));
    plan.push_back(pixel_row(12'd4095, 12'd0,    1'b0, 16'd0));
    plan.push_back(pixel_row(12'd0,    12'd4095, 1'b0, 16'd0));
    plan.push_back(pixel_row(12'd4095, 12'd4095, 1'b0, 16'd0));
    // whole image on the origin at the largest limit: one full-length orbit
    plan.push_back(write_row(REG_ORIGIN_REAL, 32'd0));
    plan.push_back(write_row(REG_ORIGIN_IMAG, 32'd0));
    plan.push_back(write_row(REG_STEP_REAL,   32'd0));
    plan.push_back(write_row(REG_STEP_IMAG,   32'd0));
    plan.push_back(write_row(REG_ITER_LIMIT,  32'd65535));
    plan.push_back(pixel_row(12'd4095, 12'd4095, 1'b1, 16'd65535));
    // one-LSB steps next to the tip of the set
    plan.push_back(write_row(REG_ORIGIN_REAL, 32'hE000_0000));
    plan.push_back(write_row(REG_STEP_REAL,   32'd1));
    plan.push_back(write_row(REG_STEP_IMAG,   32'd1));
    plan.push_back(write_row(REG_ITER_LIMIT,  32'd200));
    plan.push_back(pixel_row(12'd4095, 12'd4095, 1'b0, 16'd0));
    plan.push_back(pixel_row(12'd0,    12'd0,    1'b0, 16'd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      pr = plan[i];
      if (pr.kind == ROW_WRITE) begin
        settle();
        write_reg(pr.index, pr.data);
      end else begin
        send_pixel(pr.col, pr.rw, pr.typed_in, pr.want);
      end
    end
    directed_pixels = pixels_sent;

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 77 : 20);
      region = $urandom_range(0, 9);
      if (region < 6) begin
        // whole-set view: real -2.5..-1.5 upward, imag -2.0..-1.5 upward
        o_re = -32'sd671088640 + $urandom_range(0, 268435456);
        o_im = -32'sd402653184 - $urandom_range(0, 134217728);
        s_re = $urandom_range(65536, 262144);
        s_im = $urandom_range(65536, 262144);
      end else if (region < 8) begin
        // zoom onto the boundary near -0.75, steps of 1 to 4096 LSBs either way
        o_re = $urandom_range(0, 67108864) - 32'sd234881024;
        o_im = $urandom_range(0, 67108864);
        s_re = $urandom_range(1, 4096);
        s_im = $urandom_range(1, 4096);
        if ($urandom_range(1)) s_re = -s_re;
        if ($urandom_range(1)) s_im = -s_im;
      end else if (region == 8) begin
        o_re = $urandom();
        o_im = $urandom();
        s_re = $urandom();
        s_im = $urandom();
      end else begin
        // mirrored view walking leftward from the right edge
        o_re = 32'sd268435456 + $urandom_range(0, 134217728);
        o_im = 32'sd402653184 + $urandom_range(0, 134217728);
        s_re = -$urandom_range(65536, 262144);
        s_im = -$urandom_range(65536, 262144);
        stray_idx = REG_UNUSED_LO + CFG_IDX_W'($urandom_range(2));
        write_reg(stray_idx, $urandom());
      end
      lim = ITER_W'(($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 48));
      junk = ITER_W'($urandom_range(65535));
      write_reg(REG_ORIGIN_REAL, o_re);
      write_reg(REG_ORIGIN_IMAG, o_im);
      write_reg(REG_STEP_REAL, s_re);
      write_reg(REG_STEP_IMAG, s_im);
      write_reg(REG_ITER_LIMIT, {junk, lim});
      for (n = 0; n < PIXELS_PER_PHASE; n++) begin
        send_pixel(PIX_W'($urandom_range(4095)), PIX_W'($urandom_range(4095)), 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d pixels (%0d from the directed table) over %0d register writes,",
             pixels_sent, directed_pixels, reg_writes);
    $display("limits from zero up to %0d; %0d results checked, %0d mismatches.",
             deepest, checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
